// ----- rtl/fmd_pkg.sv -----
// fmd_pkg: shared types and constants for the fm polar discriminator
// holds the datapath widths, the vector struct that moves between cells and
// the cordic angle table; no dependencies
package fmd_pkg;

  // datapath widths
  localparam int XY_W         = 64;   // product and cordic vector width
  localparam int TURN_W       = 32;   // angle accumulator, 2^TURN_W counts a turn
  localparam int NORM_TOP     = 58;   // normalised magnitude stays below 2^NORM_TOP
  localparam int NORM_STEPS   = 6;    // binary shift steps 32,16,8,4,2,1
  localparam int CORDIC_STEPS = 32;

  typedef logic signed [XY_W-1:0] fmd_xy_t;
  typedef logic [TURN_W-1:0]      fmd_turn_t;

  // half a turn, start angle for vectors in the left half plane
  localparam fmd_turn_t TURN_HALF = fmd_turn_t'(1) << (TURN_W - 1);

  // vector and angle carried along the chain
  typedef struct packed {
    logic      zero;
    fmd_xy_t   x;
    fmd_xy_t   y;
    fmd_turn_t acc;
  } fmd_vec_t;

  // atan(2^-k) in units of 2^-32 turn
  localparam fmd_turn_t TURN_TABLE [CORDIC_STEPS] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

endpackage

// ----- rtl/fmd_front.sv -----
// fmd_front: previous-sample register and conjugate product front end
// two stages: four registered multiplies, then the x / y sums
// depends on fmd_pkg
module fmd_front import fmd_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  output logic                           out_vld,
  output fmd_vec_t                       out_vec
);

  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int PRE    = (PROD_W > 60) ? (PROD_W - 60) : 0;

  logic signed [SAMPLE_WIDTH-1:0] prior_i_r, prior_q_r;
  logic signed [PROD_W-1:0]       p_ac_r, p_bd_r, p_bc_r, p_ad_r;
  logic signed [PROD_W-1:0]       p_ac_nxt, p_bd_nxt, p_bc_nxt, p_ad_nxt;
  logic                           p_vld_r;
  logic                           vec_vld_r;
  fmd_vec_t                       vec_r, vec_nxt;
  fmd_xy_t                        ac_s, bd_s, bc_s, ad_s;

  // previous sample, updated on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_i_r <= '0;
      prior_q_r <= '0;
    end else if (en && in_vld) begin
      prior_i_r <= in_i;
      prior_q_r <= in_q;
    end
  end

  // sample times conjugate of previous sample, partial products
  always_comb begin
    p_ac_nxt = PROD_W'(in_i) * PROD_W'(prior_i_r);
    p_bd_nxt = PROD_W'(in_q) * PROD_W'(prior_q_r);
    p_bc_nxt = PROD_W'(in_q) * PROD_W'(prior_i_r);
    p_ad_nxt = PROD_W'(in_i) * PROD_W'(prior_q_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ac_r <= p_ac_nxt;
      p_bd_r <= p_bd_nxt;
      p_bc_r <= p_bc_nxt;
      p_ad_r <= p_ad_nxt;
    end
  end

  // floor prescale for wide samples, then real and imaginary sums
  always_comb begin
    ac_s    = fmd_xy_t'(p_ac_r >>> PRE);
    bd_s    = fmd_xy_t'(p_bd_r >>> PRE);
    bc_s    = fmd_xy_t'(p_bc_r >>> PRE);
    ad_s    = fmd_xy_t'(p_ad_r >>> PRE);
    vec_nxt = '{zero: 1'b0, x: ac_s + bd_s, y: bc_s - ad_s, acc: '0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      vec_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r   <= in_vld;
      vec_vld_r <= p_vld_r;
    end
  end

  assign out_vld = vec_vld_r;
  assign out_vec = vec_r;

endmodule

// ----- rtl/fmd_norm_cell.sv -----
// fmd_norm_cell: one step of the binary normalising shift
// doubles x and y together SHIFT times when both stay in range
// depends on fmd_pkg
module fmd_norm_cell import fmd_pkg::*; #(
  parameter int SHIFT = 1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  fmd_vec_t in_vec,
  output logic     out_vld,
  output fmd_vec_t out_vec
);

  localparam int      LIM     = NORM_TOP - SHIFT;
  localparam fmd_xy_t POS_LIM = fmd_xy_t'(1) <<< LIM;
  localparam fmd_xy_t NEG_LIM = -POS_LIM;

  logic     fits;
  logic     vld_r;
  fmd_vec_t vec_r, vec_nxt;

  // shift only while the larger magnitude stays below the limit
  always_comb begin
    fits    = (in_vec.x < POS_LIM) && (in_vec.x > NEG_LIM) &&
              (in_vec.y < POS_LIM) && (in_vec.y > NEG_LIM);
    vec_nxt = in_vec;
    if (fits) begin
      vec_nxt.x = in_vec.x <<< SHIFT;
      vec_nxt.y = in_vec.y <<< SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_vec = vec_r;

endmodule

// ----- rtl/fmd_cordic_cell.sv -----
// fmd_cordic_cell: one vectoring cordic micro-rotation
// rotates towards the x axis by atan(2^-IDX) and updates the angle
// depends on fmd_pkg
module fmd_cordic_cell import fmd_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  fmd_vec_t in_vec,
  output logic     out_vld,
  output fmd_vec_t out_vec
);

  fmd_xy_t  xs, ys;
  logic     vld_r;
  fmd_vec_t vec_r, vec_nxt;

  // rotate clockwise for y >= 0, otherwise counter-clockwise
  always_comb begin
    xs      = in_vec.x >>> IDX;
    ys      = in_vec.y >>> IDX;
    vec_nxt = in_vec;
    if (!in_vec.y[XY_W-1]) begin
      vec_nxt.x   = in_vec.x + ys;
      vec_nxt.y   = in_vec.y - xs;
      vec_nxt.acc = in_vec.acc + TURN_TABLE[IDX];
    end else begin
      vec_nxt.x   = in_vec.x - ys;
      vec_nxt.y   = in_vec.y + xs;
      vec_nxt.acc = in_vec.acc - TURN_TABLE[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_vec = vec_r;

endmodule

// ----- rtl/fm_frequency_demodulator.sv -----
// fm_frequency_demodulator: fm polar discriminator top level
// front end, normalising cells, half-plane fold, cordic cell chain, output skid
// depends on fmd_pkg, fmd_front, fmd_norm_cell, fmd_cordic_cell
//
// Usage
//   in channel : one complex sample per request (in_sample_i, in_sample_q)
//   out channel: one phase step per request, the angle of the sample times
//                the conjugate of the previous one; 2^ANGLE_WIDTH counts
//                make one turn, so half the code range is pi radians
//   throughput : one request per cycle, sustained while the skid register is empty
//   pipeline   : an accepted input request passes 2 front-end stages,
//                6 normalising shift cells, 1 fold stage and 32 cordic
//                cells, then the output register, before out_valid
//   reset      : synchronous, active low; clears every valid and the stored
//                previous sample, so the first phase step after reset is 0
//   stall      : the whole chain advances together; while the receiver
//                holds out_ready low one more result is parked in a skid
//                register, and in_ready drops only while that skid is full
//   a zero product (zero sample or zero previous sample) gives phase 0
module fm_frequency_demodulator import fmd_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ANGLE_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_q,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ANGLE_WIDTH-1:0]  out_phase_step
);

  localparam fmd_turn_t ROUND_HALF = (ANGLE_WIDTH < TURN_W) ?
                                     (fmd_turn_t'(1) << (TURN_W - 1 - ANGLE_WIDTH)) : '0;

  logic                          en;
  logic                          norm_vld [0:NORM_STEPS];
  fmd_vec_t                      norm_vec [0:NORM_STEPS];
  logic                          cor_vld  [0:CORDIC_STEPS];
  fmd_vec_t                      cor_vec  [0:CORDIC_STEPS];
  fmd_vec_t                      fold_nxt;
  logic                          fold_vld_r;
  fmd_vec_t                      fold_vec_r;
  fmd_turn_t                     acc_fin, acc_rnd;
  logic signed [ANGLE_WIDTH-1:0] pipe_phase;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [ANGLE_WIDTH-1:0] out_phase_r, out_phase_nxt;
  logic                          skid_valid_r, skid_valid_nxt;
  logic signed [ANGLE_WIDTH-1:0] skid_phase_r, skid_phase_nxt;

  // chain advances unless the skid register holds a result
  assign en       = !skid_valid_r;
  assign in_ready = en;

  // conjugate product front end
  fmd_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .in_i   (in_sample_i),
    .in_q   (in_sample_q),
    .out_vld(norm_vld[0]),
    .out_vec(norm_vec[0])
  );

  // normalising shifts, largest step first
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    fmd_norm_cell #(
      .SHIFT(1 << (NORM_STEPS - 1 - j))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (norm_vld[j]),
      .in_vec (norm_vec[j]),
      .out_vld(norm_vld[j+1]),
      .out_vec(norm_vec[j+1])
    );
  end

  // fold left half plane onto the right, flag the zero vector
  always_comb begin
    fold_nxt      = norm_vec[NORM_STEPS];
    fold_nxt.zero = (norm_vec[NORM_STEPS].x == '0) && (norm_vec[NORM_STEPS].y == '0);
    fold_nxt.acc  = '0;
    if (norm_vec[NORM_STEPS].x[XY_W-1]) begin
      fold_nxt.x   = -norm_vec[NORM_STEPS].x;
      fold_nxt.y   = -norm_vec[NORM_STEPS].y;
      fold_nxt.acc = TURN_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_vld_r <= 1'b0;
    end else if (en) begin
      fold_vld_r <= norm_vld[NORM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold_vec_r <= fold_nxt;
    end
  end

  assign cor_vld[0] = fold_vld_r;
  assign cor_vec[0] = fold_vec_r;

  // cordic vectoring chain
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    fmd_cordic_cell #(
      .IDX(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (cor_vld[k]),
      .in_vec (cor_vec[k]),
      .out_vld(cor_vld[k+1]),
      .out_vec(cor_vec[k+1])
    );
  end

  // round half up to the output width, zero vector gives zero angle
  always_comb begin
    acc_fin    = cor_vec[CORDIC_STEPS].zero ? '0 : cor_vec[CORDIC_STEPS].acc;
    acc_rnd    = acc_fin + ROUND_HALF;
    pipe_phase = acc_rnd[TURN_W-1 -: ANGLE_WIDTH];
  end

  // output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_phase_nxt  = out_phase_r;
    skid_valid_nxt = skid_valid_r;
    skid_phase_nxt = skid_phase_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_phase_nxt  = skid_phase_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = cor_vld[CORDIC_STEPS];
        out_phase_nxt  = pipe_phase;
      end
    end else if (!skid_valid_r && cor_vld[CORDIC_STEPS]) begin
      skid_valid_nxt = 1'b1;
      skid_phase_nxt = pipe_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_phase_r  <= out_phase_nxt;
    skid_phase_r <= skid_phase_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_phase_step = out_phase_r;

endmodule

// ----- rtl/fmd_checker.sv -----
// fmd_checker: port-level checks for the fm polar discriminator
// watches the top level's ports only; bound to fm_frequency_demodulator
// depends on nothing but the bound module's ports
module fmd_checker #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ANGLE_WIDTH  = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample_q,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [ANGLE_WIDTH-1:0]  out_phase_step
);

  logic [7:0] pending_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 8'(in_acc) - 8'(out_acc);
    end
  end

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase_step))
    else $error("stalled result changed");

  // no result without an accepted request behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 8'd0)
    else $error("result without pending request");

  // input back-pressure only while a result is held up
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("input stalled without output stall");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty after reset");

  // sample fields are watched for x-free requests
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !$isunknown(in_sample_i) && !$isunknown(in_sample_q))
    else $error("unknown sample accepted");

endmodule

bind fm_frequency_demodulator fmd_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_fmd_checker (.*);
